@@ hw/rtl/kies_pkg.sv @@
// shared types and constants of the key index exchange sort block
// used by every rtl file of the block; depends on nothing

package kies_pkg;

   // field widths of one key record
   localparam int HIGH_W = 64;
   localparam int LOW_W  = 32;
   localparam int IDX_W  = 6;

   // default capacity of the key store
   localparam int MAX_RECORDS_DEF = 64;

   // one stored key with its arrival index
   typedef struct packed {
      logic [HIGH_W-1:0] key_high;
      logic [LOW_W-1:0]  key_low;
      logic [IDX_W-1:0]  index;
   } rec_type;

   // sequencer to output stage control
   typedef struct packed {
      logic load;
      logic final_entry;
   } out_ctl_type;

endpackage

@@ hw/rtl/kies_ram.sv @@
// key record memory: one write port, one read port, registered read data
// depends on kies_pkg for the record type

module kies_ram #(
   parameter int DEPTH = kies_pkg::MAX_RECORDS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  kies_pkg::rec_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output kies_pkg::rec_type rd_data
);

   kies_pkg::rec_type mem [DEPTH];
   kies_pkg::rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/kies_seq.sv @@
// load, exchange sort and read-out sequencer for the key record memory
// depends on kies_pkg; drives kies_ram and the output stage of the top level

module kies_seq #(
   parameter int MAX_RECORDS = kies_pkg::MAX_RECORDS_DEF,
   parameter int AW          = $clog2(MAX_RECORDS),
   parameter int CW          = $clog2(MAX_RECORDS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kies_pkg::HIGH_W-1:0]   req_key_high,
   input  logic [kies_pkg::LOW_W-1:0]    req_key_low,
   input  logic                          req_last_key,
   // memory
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output kies_pkg::rec_type             wr_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   input  kies_pkg::rec_type             rd_data,
   // output stage
   output kies_pkg::out_ctl_type         out_ctl,
   input  logic                          rsp_taken
);

   localparam int IW = kies_pkg::IDX_W;

   typedef enum logic [6:0] {
      S_LOAD     = 7'b0000001,
      S_RD_I     = 7'b0000010,
      S_LD_I     = 7'b0000100,
      S_CMP      = 7'b0001000,
      S_WB_I     = 7'b0010000,
      S_OUT_RD   = 7'b0100000,
      S_OUT_CAP  = 7'b1000000
   } state_type;

   // note: the wait for a result transfer is a flag held in S_LOAD, not a state
   state_type         state_ff, state_in;
   logic              wait_ff, wait_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     i_ff, i_in;     // outer sort index, then read-out index
   logic [AW-1:0]     j_ff, j_in;
   kies_pkg::rec_type cur_ff, cur_in; // entry i held while j sweeps

   logic [CW-1:0]     count_m1;
   logic [AW-1:0]     last_addr;
   logic              room;
   logic              req_xfer;
   logic [CW-1:0]     count_new;
   logic              cur_greater;

   assign count_m1  = count_ff - CW'(1);
   assign last_addr = count_m1[AW-1:0];
   assign room      = count_ff < CW'(MAX_RECORDS);
   assign req_ready = (state_ff == S_LOAD) && !wait_ff;
   assign req_xfer  = req_valid && req_ready;
   assign count_new = room ? count_ff + CW'(1) : count_ff;

   // 96-bit unsigned compare, high word first
   assign cur_greater = {cur_ff.key_high, cur_ff.key_low} >
                        {rd_data.key_high, rd_data.key_low};

   // next state and datapath
   always_comb begin
      state_in            = state_ff;
      wait_in             = wait_ff;
      count_in            = count_ff;
      i_in                = i_ff;
      j_in                = j_ff;
      cur_in              = cur_ff;
      wr_en               = 1'b0;
      wr_addr             = count_ff[AW-1:0];
      wr_data             = cur_ff;
      rd_en               = 1'b0;
      rd_addr             = i_ff;
      out_ctl.load        = 1'b0;
      out_ctl.final_entry = 1'b0;

      case (state_ff)
         S_LOAD: begin
            if (wait_ff) begin
               // result on show, waiting for its transfer
               if (rsp_taken) begin
                  wait_in = 1'b0;
                  if (i_ff == last_addr) begin
                     count_in = '0;
                  end else begin
                     i_in     = i_ff + AW'(1);
                     rd_en    = 1'b1;
                     rd_addr  = i_ff + AW'(1);
                     state_in = S_OUT_CAP;
                  end
               end
            end else if (req_xfer) begin
               // store the key unless the store is full
               wr_en            = room;
               wr_addr          = count_ff[AW-1:0];
               wr_data.key_high = req_key_high;
               wr_data.key_low  = req_key_low;
               wr_data.index    = IW'(count_ff);
               count_in         = count_new;
               i_in             = '0;
               if (req_last_key) begin
                  if (count_new == CW'(1)) begin
                     state_in = S_OUT_RD;
                  end else begin
                     state_in = S_RD_I;
                  end
               end
            end
         end
         S_RD_I: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = S_LD_I;
         end
         S_LD_I: begin
            cur_in   = rd_data;
            j_in     = i_ff + AW'(1);
            rd_en    = 1'b1;
            rd_addr  = i_ff + AW'(1);
            state_in = S_CMP;
         end
         S_CMP: begin
            // swap: old entry i goes to j, entry j is held as the new i
            if (cur_greater) begin
               wr_en   = 1'b1;
               wr_addr = j_ff;
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            if (j_ff == last_addr) begin
               state_in = S_WB_I;
            end else begin
               j_in    = j_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = j_ff + AW'(1);
            end
         end
         S_WB_I: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = cur_ff;
            if (i_ff + AW'(1) == last_addr) begin
               i_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_RD_I;
            end
         end
         S_OUT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff;
            state_in = S_OUT_CAP;
         end
         S_OUT_CAP: begin
            out_ctl.load        = 1'b1;
            out_ctl.final_entry = (i_ff == last_addr);
            wait_in             = 1'b1;
            state_in            = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
            wait_in  = 1'b0;
            count_in = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         wait_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         count_ff <= count_in;
      end
   end

   // indices and held entry
   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      cur_ff <= cur_in;
   end

endmodule

@@ hw/rtl/key_index_exchange_sort.sv @@
// top level of the key index exchange sort block: output register stage,
// sequencer kies_seq and record memory kies_ram; uses kies_pkg
//
// Keys are taken one per cycle and stored with their arrival index; a key
// that arrives while MAX_RECORDS keys are held is dropped. The transfer
// marked last_key starts an exchange sort of the n held keys in the record
// memory: entry i is held in a register while entries i+1 to n-1 are read
// one per cycle, with one compare per pair of entries and, for each entry
// i, the states S_RD_I, S_LD_I and S_WB_I to load and write it back, a cost
// set by the single read port of the memory. The sorted keys then leave
// one at a time, each read from memory into the output register only
// after the one before has been transferred, the last one marked by
// final_entry; no key is accepted until that last transfer.

module key_index_exchange_sort #(
   parameter int MAX_RECORDS = kies_pkg::MAX_RECORDS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [kies_pkg::HIGH_W-1:0]   req_key_high,
   input  logic [kies_pkg::LOW_W-1:0]    req_key_low,
   input  logic                          req_last_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [kies_pkg::HIGH_W-1:0]   rsp_sorted_high,
   output logic [kies_pkg::LOW_W-1:0]    rsp_sorted_low,
   output logic [kies_pkg::IDX_W-1:0]    rsp_record_index,
   output logic                          rsp_final_entry
);

   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   kies_pkg::rec_type     wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   kies_pkg::rec_type     rd_data;
   kies_pkg::out_ctl_type out_ctl;
   logic                  rsp_taken;

   logic                  rsp_valid_ff, rsp_valid_in;
   kies_pkg::rec_type     rsp_rec_ff;
   logic                  rsp_final_ff;

   assign rsp_taken = rsp_valid_ff && rsp_ready;

   kies_seq #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW),
      .CW          (CW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_high (req_key_high),
      .req_key_low  (req_key_low),
      .req_last_key (req_last_key),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .out_ctl      (out_ctl),
      .rsp_taken    (rsp_taken)
   );

   kies_ram #(
      .DEPTH (MAX_RECORDS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output valid: set on capture, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (out_ctl.load) begin
         rsp_rec_ff   <= rd_data;
         rsp_final_ff <= out_ctl.final_entry;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_high  = rsp_rec_ff.key_high;
   assign rsp_sorted_low   = rsp_rec_ff.key_low;
   assign rsp_record_index = rsp_rec_ff.index;
   assign rsp_final_entry  = rsp_final_ff;

endmodule

@@ hw/rtl/kies_checker.sv @@
// port-level checks of the key index exchange sort block
// depends on kies_pkg for field widths; bound to key_index_exchange_sort

module kies_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last_key,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [kies_pkg::HIGH_W-1:0]   rsp_sorted_high,
   input logic [kies_pkg::LOW_W-1:0]    rsp_sorted_low,
   input logic [kies_pkg::IDX_W-1:0]    rsp_record_index,
   input logic                          rsp_final_entry
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_high) &&
      $stable(rsp_sorted_low) && $stable(rsp_record_index) &&
      $stable(rsp_final_entry))
   else $error("stalled result changed");

   // after reset: loading, nothing on show
   assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
   else $error("bad state after reset");

   // no key taken while results are on show
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
   else $error("input open during read-out");

   // last key ends loading
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_key |=> !req_ready)
   else $error("still loading after last key");

   // final transfer returns to loading, earlier ones do not
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> (req_ready == $past(rsp_final_entry)))
   else $error("wrong state after result transfer");

endmodule

bind key_index_exchange_sort kies_checker u_kies_checker (.*);

@@ verif/tb.sv @@
// testbench for key_index_exchange_sort: directed and random key sets, scoreboard check
// depends on kies_pkg and the rtl top level key_index_exchange_sort

module tb;

   localparam int CAPACITY     = kies_pkg::MAX_RECORDS_DEF;
   localparam int HW           = kies_pkg::HIGH_W;
   localparam int LW           = kies_pkg::LOW_W;
   localparam int XW           = kies_pkg::IDX_W;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 400000;

   // one expected sorted key with its end-of-run flag
   typedef struct {
      kies_pkg::rec_type rec;
      logic              final_entry;
   } sorted_rec_type;

   // scoreboard: mirrors the key store and keeps the sorted keys still owed
   class sort_scoreboard;
      logic [HW-1:0]  held_high  [CAPACITY];
      logic [LW-1:0]  held_low   [CAPACITY];
      logic [XW-1:0]  held_index [CAPACITY];
      int             held_count;
      sorted_rec_type sorted_q [$];
      int             errors;

      function new();
         held_count = 0;
         errors     = 0;
      endfunction

      function int pending();
         return sorted_q.size();
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) begin
            $display("%s", msg);
         end
      endfunction

      // high bytes decide first, then the low bytes
      function bit key_above(int a, int b);
         if (held_high[a] != held_high[b]) begin
            return held_high[a] > held_high[b];
         end
         return held_low[a] > held_low[b];
      endfunction

      // accepted key: store it, and on the last key sort and queue the run
      function void note_key(logic [HW-1:0] kh, logic [LW-1:0] kl, logic last);
         logic [HW-1:0]  th;
         logic [LW-1:0]  tl;
         logic [XW-1:0]  tx;
         sorted_rec_type r;
         if (held_count < CAPACITY) begin
            held_high[held_count]  = kh;
            held_low[held_count]   = kl;
            held_index[held_count] = XW'(held_count);
            held_count++;
         end
         if (!last) begin
            return;
         end
         for (int i = 0; i < held_count; i++) begin
            for (int j = i + 1; j < held_count; j++) begin
               if (key_above(i, j)) begin
                  th = held_high[i];  tl = held_low[i];  tx = held_index[i];
                  held_high[i]  = held_high[j];
                  held_low[i]   = held_low[j];
                  held_index[i] = held_index[j];
                  held_high[j]  = th;  held_low[j] = tl;  held_index[j] = tx;
               end
            end
         end
         for (int i = 0; i < held_count; i++) begin
            r.rec.key_high = held_high[i];
            r.rec.key_low  = held_low[i];
            r.rec.index    = held_index[i];
            r.final_entry  = (i == held_count - 1);
            sorted_q.push_back(r);
         end
         held_count = 0;
      endfunction

      // result transfer: compare with the oldest sorted key owed
      function void check_rsp(logic [HW-1:0] sh, logic [LW-1:0] sl, logic [XW-1:0] sx,
                              logic fin);
         sorted_rec_type e;
         if (sorted_q.size() == 0) begin
            report($sformatf("unexpected result: high %h low %h index %0d final %b",
                             sh, sl, sx, fin));
            return;
         end
         e = sorted_q.pop_front();
         if (e.rec.key_high !== sh || e.rec.key_low !== sl || e.rec.index !== sx ||
             e.final_entry !== fin) begin
            report($sformatf({"mismatch: expected high %h low %h index %0d final %b, ",
                              "got high %h low %h index %0d final %b"},
                             e.rec.key_high, e.rec.key_low, e.rec.index, e.final_entry,
                             sh, sl, sx, fin));
         end
      endfunction

      function void close();
         if (sorted_q.size() != 0) begin
            report($sformatf("%0d sorted results never arrived", sorted_q.size()));
         end
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [HW-1:0] req_key_high;
   logic [LW-1:0] req_key_low;
   logic          req_last_key;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [HW-1:0] rsp_sorted_high;
   logic [LW-1:0] rsp_sorted_low;
   logic [XW-1:0] rsp_record_index;
   logic          rsp_final_entry;

   sort_scoreboard sb = new();
   bit             no_idle = 1'b0;
   int             cycle_count = 0;

   key_index_exchange_sort #(.MAX_RECORDS(CAPACITY)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_high     (req_key_high),
      .req_key_low      (req_key_low),
      .req_last_key     (req_last_key),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_high  (rsp_sorted_high),
      .rsp_sorted_low   (rsp_sorted_low),
      .rsp_record_index (rsp_record_index),
      .rsp_final_entry  (rsp_final_entry)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stalls, check every transfer
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_rsp(rsp_sorted_high, rsp_sorted_low, rsp_record_index, rsp_final_entry);
      end
   end

   // one key transfer after a random gap
   task send_key(input logic [HW-1:0] kh, input logic [LW-1:0] kl, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_key_high <= kh;
      req_key_low  <= kl;
      req_last_key <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_key(kh, kl, last);
   endtask

   // hold the sender until every sorted key owed has come back
   task wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // random key: full random, small pool with ties, or name-like bytes
   task draw_key(input int mode, output logic [HW-1:0] kh, output logic [LW-1:0] kl);
      logic [95:0] name;
      int          len;
      int          m;
      m = (mode == 3) ? $urandom_range(0, 2) : mode;
      case (m)
         0: begin
            kh = {$urandom, $urandom};
            kl = $urandom;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: kh = '0;
               1: kh = '1;
               2: kh = 64'h4142_4300_0000_0000;
               default: kh = 64'h4142_4344_0000_0000;
            endcase
            kl = LW'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0) kl = '1;
         end
         default: begin
            name = '0;
            len  = $urandom_range(0, 12);
            for (int b = 0; b < 12; b++) begin
               if (b < len) name[95 - 8*b -: 8] = 8'(8'h41 + $urandom_range(0, 25));
            end
            // a stray byte after the zero padding
            if (len < 11 && $urandom_range(0, 5) == 0) begin
               name[95 - 8*(len + 1) -: 8] = 8'($urandom_range(1, 255));
            end
            kh = name[95:32];
            kl = name[31:0];
         end
      endcase
   endtask

   // stimulus
   initial begin
      int            sent;
      int            set_count;
      int            size;
      int            mode;
      logic [HW-1:0] kh;
      logic [LW-1:0] kl;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_key_high <= '0;
      req_key_low  <= '0;
      req_last_key <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single-key sets at both extremes
      send_key('0, '0, 1'b1);
      send_key('1, '1, 1'b1);
      // order decided by the low bytes alone, plus extremes
      send_key(64'h4142_4344_0000_0000, 32'd5, 1'b0);
      send_key(64'h4142_4344_0000_0000, 32'd4, 1'b0);
      send_key('1, '1, 1'b0);
      send_key('0, '0, 1'b1);
      // equal keys stay unswapped
      send_key(64'h5a5a_0000_0000_0000, 32'h1, 1'b0);
      send_key(64'h5a5a_0000_0000_0000, 32'h1, 1'b0);
      send_key(64'h5a5a_0000_0000_0000, 32'h1, 1'b1);
      // bytes after a zero byte still count
      send_key(64'h4142_0043_0000_0000, 32'h0, 1'b0);
      send_key(64'h4142_0000_0000_0000, 32'h0000_0001, 1'b0);
      send_key(64'h4142_0000_0000_0000, 32'h0, 1'b1);
      // reverse ordered set
      send_key(64'h8000_0000_0000_0000, 32'h0, 1'b0);
      send_key(64'h0000_0000_0000_0001, 32'h8000_0000, 1'b0);
      send_key(64'h0000_0000_0000_0001, 32'h7fff_ffff, 1'b0);
      send_key(64'h0000_0000_0000_0000, 32'hffff_ffff, 1'b0);
      send_key(64'h0000_0000_0000_0000, 32'h0000_0001, 1'b1);
      wait_drained();

      // random sets, mostly small, a few full and overfull
      sent      = 0;
      set_count = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0:       size = $urandom_range(CAPACITY, CAPACITY + 4);
            1, 2, 3: size = $urandom_range(9, 24);
            default: size = $urandom_range(1, 8);
         endcase
         if (set_count == 2) size = CAPACITY + 2;
         if (set_count == 5) size = CAPACITY;
         no_idle = ($urandom_range(0, 4) == 0);
         mode    = $urandom_range(0, 3);
         for (int k = 0; k < size; k++) begin
            draw_key(mode, kh, kl);
            send_key(kh, kl, k == size - 1);
         end
         sent += size;
         set_count++;
         if (set_count % 8 == 0) wait_drained();
      end
      no_idle = 1'b0;

      // drain and let the block settle
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/kies_pkg.sv
hw/rtl/kies_ram.sv
hw/rtl/kies_seq.sv
hw/rtl/key_index_exchange_sort.sv
hw/rtl/kies_checker.sv
verif/tb.sv
